// ----- rtl/hat_pkg.sv -----
// Package with the types, constants and hash function of the hash accumulate table.
`timescale 1ns / 1ps

package hat_pkg;

   localparam int INDEX_BITS  = 12;
   localparam int ORDER_DEPTH = 4096;
   localparam int ORDER_BITS  = $clog2(ORDER_DEPTH);
   localparam int COUNT_BITS  = ORDER_BITS + 1;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 30;

   localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_NEXT   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_NEW     = 3'd0,
      STATUS_ACCUM   = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_CLEARED = 3'd3,
      STATUS_ENTRY   = 3'd4,
      STATUS_NONE    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PROBE,
      S_CLEAR,
      S_NEXT_ORDER,
      S_NEXT_SLOT,
      S_NEXT_CHECK
   } state_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] amount;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [KEY_BITS-1:0]   entry_key;
      logic [VALUE_BITS-1:0] entry_value;
   } rsp_type;

   typedef struct packed {
      logic                  used;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   // Only the low index bits of key and multiplier reach the low index bits of the product.
   function automatic logic [INDEX_BITS-1:0] hash_index(input logic [KEY_BITS-1:0] key);
      logic [2*INDEX_BITS-1:0] prod;
      prod = (2*INDEX_BITS)'(key[INDEX_BITS-1:0]) * (2*INDEX_BITS)'(HASH_MULT[INDEX_BITS-1:0]);
      return prod[INDEX_BITS-1:0];
   endfunction

endpackage

// ----- rtl/hat_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module hat_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/hash_accumulate_table.sv -----
// Top level of the accumulating linear-probing hash table.
// A request is taken at a clock edge where start is high and busy is low. Opcode insert
// adds amount to the value stored under key, creating the entry when the key is new.
// Opcode clear empties every slot on the insertion-order list. Opcode next returns the
// next entry in insertion order whose value is not zero. Every request gives exactly one
// response, shown on rsp_data for one cycle with rsp_valid high; the receiver cannot
// stall it, and the next request may be taken in the cycle the response is shown.
// An insert probes the slots in turn from the home slot, reading each one through the
// one read port of the slot memory.
// A clear walks the order memory and empties each slot that it lists.
// A next request visits the list entries in turn, reading the order memory and then
// the slot memory for each, until it finds a value that is not zero or runs off the
// end of the list.
// After reset the block sweeps all 4096 slots of the slot memory, one slot a cycle, with
// busy high; the table is then empty and the gather cursor is at the start of the list.

`timescale 1ns / 1ps

module hash_accumulate_table (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  hat_pkg::req_type req_data,
   output logic            rsp_valid,
   output hat_pkg::rsp_type rsp_data
);

   hat_pkg::state_type                   state_ff, state_in;
   logic [hat_pkg::INDEX_BITS-1:0]       pos_ff, pos_in;
   logic [hat_pkg::INDEX_BITS-1:0]       probe_ff, probe_in;
   logic [hat_pkg::INDEX_BITS-1:0]       init_ff, init_in;
   logic [hat_pkg::COUNT_BITS-1:0]       idx_ff, idx_in;
   logic                                 pend_ff, pend_in;
   logic [hat_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [hat_pkg::COUNT_BITS-1:0]       cursor_ff, cursor_in;
   logic [hat_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [hat_pkg::VALUE_BITS-1:0]       amt_ff, amt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   hat_pkg::rsp_type                     rsp_ff, rsp_in;

   logic                                 slot_we;
   logic [hat_pkg::INDEX_BITS-1:0]       slot_waddr, slot_raddr;
   hat_pkg::slot_type                    slot_wdata, slot_rdata;
   logic                                 order_we;
   logic [hat_pkg::ORDER_BITS-1:0]       order_waddr, order_raddr;
   logic [hat_pkg::INDEX_BITS-1:0]       order_wdata, order_rdata;
   logic [hat_pkg::INDEX_BITS-1:0]       hash_pos;

   hat_ram #(
      .ADDR_BITS(hat_pkg::INDEX_BITS),
      .DATA_BITS($bits(hat_pkg::slot_type))
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_addr(slot_raddr),
      .rd_data(slot_rdata)
   );

   hat_ram #(
      .ADDR_BITS(hat_pkg::ORDER_BITS),
      .DATA_BITS(hat_pkg::INDEX_BITS)
   ) u_order_ram (
      .clock  (clock),
      .wr_en  (order_we),
      .wr_addr(order_waddr),
      .wr_data(order_wdata),
      .rd_addr(order_raddr),
      .rd_data(order_rdata)
   );

   assign hash_pos  = hat_pkg::hash_index(req_data.key);
   assign busy      = (state_ff != hat_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hat_pkg::S_INIT;
         init_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      probe_ff <= probe_in;
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      amt_ff   <= amt_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      probe_in     = probe_ff;
      init_in      = init_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      key_in       = key_ff;
      amt_in       = amt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      slot_we      = 1'b0;
      slot_waddr   = pos_ff;
      slot_wdata   = '0;
      slot_raddr   = pos_ff;
      order_we     = 1'b0;
      order_waddr  = count_ff[hat_pkg::ORDER_BITS-1:0];
      order_wdata  = pos_ff;
      order_raddr  = cursor_ff[hat_pkg::ORDER_BITS-1:0];

      case (state_ff)
         hat_pkg::S_INIT: begin
            slot_we    = 1'b1;
            slot_waddr = init_ff;
            init_in    = init_ff + 1'b1;
            if (init_ff == '1) begin
               state_in = hat_pkg::S_IDLE;
            end
         end

         hat_pkg::S_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  hat_pkg::OP_INSERT: begin
                     key_in     = req_data.key;
                     amt_in     = req_data.amount;
                     pos_in     = hash_pos;
                     slot_raddr = hash_pos;
                     probe_in   = '0;
                     cursor_in  = '0;
                     state_in   = hat_pkg::S_PROBE;
                  end
                  hat_pkg::OP_CLEAR: begin
                     idx_in   = '0;
                     state_in = hat_pkg::S_CLEAR;
                  end
                  hat_pkg::OP_NEXT: begin
                     state_in = hat_pkg::S_NEXT_ORDER;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = hat_pkg::STATUS_NONE;
                  end
               endcase
            end
         end

         hat_pkg::S_PROBE: begin
            if (!slot_rdata.used) begin
               rsp_valid_in = 1'b1;
               state_in     = hat_pkg::S_IDLE;
               if (count_ff >= hat_pkg::COUNT_BITS'(hat_pkg::ORDER_DEPTH)) begin
                  rsp_in.status = hat_pkg::STATUS_FULL;
               end else begin
                  slot_we          = 1'b1;
                  slot_wdata.used  = 1'b1;
                  slot_wdata.key   = key_ff;
                  slot_wdata.value = amt_ff;
                  order_we         = 1'b1;
                  count_in         = count_ff + 1'b1;
                  rsp_in.status    = hat_pkg::STATUS_NEW;
               end
            end else if (slot_rdata.key == key_ff) begin
               slot_we          = 1'b1;
               slot_wdata.used  = 1'b1;
               slot_wdata.key   = key_ff;
               slot_wdata.value = slot_rdata.value + amt_ff;
               rsp_valid_in     = 1'b1;
               rsp_in.status    = hat_pkg::STATUS_ACCUM;
               state_in         = hat_pkg::S_IDLE;
            end else if (probe_ff == '1) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = hat_pkg::STATUS_FULL;
               state_in      = hat_pkg::S_IDLE;
            end else begin
               pos_in     = pos_ff + 1'b1;
               slot_raddr = pos_ff + 1'b1;
               probe_in   = probe_ff + 1'b1;
            end
         end

         hat_pkg::S_CLEAR: begin
            order_raddr = idx_ff[hat_pkg::ORDER_BITS-1:0];
            if (pend_ff) begin
               slot_we    = 1'b1;
               slot_waddr = order_rdata;
            end
            if (idx_ff < count_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               count_in      = '0;
               cursor_in     = '0;
               rsp_valid_in  = 1'b1;
               rsp_in.status = hat_pkg::STATUS_CLEARED;
               state_in      = hat_pkg::S_IDLE;
            end
         end

         hat_pkg::S_NEXT_ORDER: begin
            if (cursor_ff < count_ff) begin
               cursor_in = cursor_ff + 1'b1;
               state_in  = hat_pkg::S_NEXT_SLOT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = hat_pkg::STATUS_NONE;
               state_in      = hat_pkg::S_IDLE;
            end
         end

         hat_pkg::S_NEXT_SLOT: begin
            slot_raddr = order_rdata;
            state_in   = hat_pkg::S_NEXT_CHECK;
         end

         hat_pkg::S_NEXT_CHECK: begin
            if (slot_rdata.value != '0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = hat_pkg::STATUS_ENTRY;
               rsp_in.entry_key   = slot_rdata.key;
               rsp_in.entry_value = slot_rdata.value;
               state_in           = hat_pkg::S_IDLE;
            end else begin
               state_in = hat_pkg::S_NEXT_ORDER;
            end
         end

         default: begin
            state_in = hat_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- verif/tb_hash_accumulate_table.sv -----
// Testbench for the hash accumulate table: predicts every response and checks each one.
`timescale 1ns / 1ps

module tb_hash_accumulate_table;

   localparam int TABLE_SLOTS = 1 << hat_pkg::INDEX_BITS;
   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_ITEMS = 1374;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   class table_scoreboard;
      bit slot_used[TABLE_SLOTS];
      bit [hat_pkg::KEY_BITS-1:0] slot_key[TABLE_SLOTS];
      bit [hat_pkg::VALUE_BITS-1:0] slot_value[TABLE_SLOTS];
      bit [hat_pkg::INDEX_BITS-1:0] insert_order[hat_pkg::ORDER_DEPTH];
      int unsigned entry_count;
      int unsigned gather_cursor;
      hat_pkg::rsp_type pending_answers[$];
      int errors;
      int status_seen[6];

      function int pending();
         return pending_answers.size();
      endfunction

      function void note_request(hat_pkg::req_type r);
         hat_pkg::rsp_type e;
         logic [31:0] prod;
         logic [hat_pkg::INDEX_BITS-1:0] pos;
         bit done;
         e = '0;
         case (r.opcode)
            hat_pkg::OP_INSERT: begin
               gather_cursor = 0;
               prod = r.key * hat_pkg::HASH_MULT;
               pos = prod[hat_pkg::INDEX_BITS-1:0];
               e.status = hat_pkg::STATUS_FULL;
               done = 0;
               for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                  if (!slot_used[pos]) begin
                     if (entry_count < hat_pkg::ORDER_DEPTH) begin
                        slot_used[pos] = 1;
                        slot_key[pos] = r.key;
                        slot_value[pos] = r.amount;
                        insert_order[entry_count] = pos;
                        entry_count++;
                        e.status = hat_pkg::STATUS_NEW;
                     end
                     done = 1;
                  end else if (slot_key[pos] == r.key) begin
                     slot_value[pos] = slot_value[pos] + r.amount;
                     e.status = hat_pkg::STATUS_ACCUM;
                     done = 1;
                  end else begin
                     pos = pos + 1'b1;
                  end
               end
            end
            hat_pkg::OP_CLEAR: begin
               for (int i = 0; i < entry_count; i++) begin
                  slot_used[insert_order[i]] = 0;
                  slot_value[insert_order[i]] = 0;
               end
               entry_count = 0;
               gather_cursor = 0;
               e.status = hat_pkg::STATUS_CLEARED;
            end
            hat_pkg::OP_NEXT: begin
               e.status = hat_pkg::STATUS_NONE;
               while (gather_cursor < entry_count && e.status == hat_pkg::STATUS_NONE) begin
                  pos = insert_order[gather_cursor];
                  gather_cursor++;
                  if (slot_value[pos] != 0) begin
                     e.status = hat_pkg::STATUS_ENTRY;
                     e.entry_key = slot_key[pos];
                     e.entry_value = slot_value[pos];
                  end
               end
            end
            default: begin
               e.status = hat_pkg::STATUS_NONE;
            end
         endcase
         status_seen[int'(e.status)]++;
         pending_answers = {pending_answers, e};
      endfunction

      function void check_response(hat_pkg::rsp_type got);
         hat_pkg::rsp_type e;
         if (pending_answers.size() == 0) begin
            $error("response with no request outstanding: status %0d", got.status);
            errors++;
            return;
         end
         e = pending_answers.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            errors++;
         end
         if (got.entry_key !== e.entry_key) begin
            $error("entry_key: expected %h, actual %h", e.entry_key, got.entry_key);
            errors++;
         end
         if (got.entry_value !== e.entry_value) begin
            $error("entry_value: expected %h, actual %h", e.entry_value, got.entry_value);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   hat_pkg::req_type req_data;
   logic rsp_valid;
   hat_pkg::rsp_type rsp_data;

   table_scoreboard board = new();
   int requests_sent;
   int idle_cycles;
   bit idle_enabled;
   logic [hat_pkg::KEY_BITS-1:0] key_pool[32];

   hash_accumulate_table dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) board.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_valid === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [hat_pkg::KEY_BITS-1:0] key,
                               input logic [hat_pkg::VALUE_BITS-1:0] amount);
      hat_pkg::req_type r;
      int gap;
      r.opcode = hat_pkg::opcode_type'(op);
      r.key = key;
      r.amount = amount;
      gap = idle_enabled ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
      requests_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [hat_pkg::VALUE_BITS-1:0] random_amount();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 30'd1;
         default: return hat_pkg::VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [hat_pkg::KEY_BITS-1:0] random_key();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return key_pool[$urandom_range(0, 31)];
   endfunction

   initial begin
      int batch;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_cycles = 0;
      requests_sent = 0;
      idle_enabled = 1'b1;
      for (int i = 0; i < 32; i++) begin
         key_pool[i] = $urandom;
         if (i >= 8) begin
            key_pool[i][hat_pkg::INDEX_BITS-1:0] = key_pool[i % 8][hat_pkg::INDEX_BITS-1:0];
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty walk, extreme keys and amounts, wrap to zero, collisions.
      send_request(hat_pkg::OP_NEXT, '0, '0);
      send_request(hat_pkg::OP_INSERT, 32'h0000_0000, 30'h0);
      send_request(hat_pkg::OP_INSERT, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_request(hat_pkg::OP_INSERT, 32'hFFFF_FFFF, 30'h1);
      send_request(hat_pkg::OP_INSERT, 32'h1234_5678, 30'h5);
      send_request(hat_pkg::OP_INSERT, 32'h1234_6678, 30'h7);
      send_request(hat_pkg::OP_INSERT, 32'h9234_7678, 30'h3FFF_FFFF);
      send_request(hat_pkg::OP_INSERT, 32'h1234_6678, 30'h10);
      send_request(hat_pkg::OP_INSERT, 32'hAAAA_AAAA, 30'h2AAA_AAAA);
      send_request(hat_pkg::OP_INSERT, 32'h5555_5555, 30'h1555_5555);
      send_request(OP_UNDEFINED, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      repeat (4) send_request(hat_pkg::OP_NEXT, '0, '0);
      send_request(hat_pkg::OP_INSERT, 32'h1234_5678, 30'h1);
      repeat (5) send_request(hat_pkg::OP_NEXT, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_request(hat_pkg::OP_CLEAR, '0, '0);
      send_request(hat_pkg::OP_NEXT, '0, '0);
      send_request(hat_pkg::OP_CLEAR, '0, '0);
      send_request(hat_pkg::OP_INSERT, 32'h1234_5678, 30'h3);
      send_request(hat_pkg::OP_NEXT, '0, '0);
      wait_drained();

      // Random part: insert batches with walks, clears, noise and drains.
      batch = requests_sent + RANDOM_ITEMS;
      while (requests_sent < batch) begin
         idle_enabled = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            7: begin
               repeat ($urandom_range(1, 10))
                  send_request(2'($urandom_range(0, 3)), $urandom,
                               hat_pkg::VALUE_BITS'($urandom));
            end
            8: wait_drained();
            9: begin
               send_request(hat_pkg::OP_CLEAR, $urandom, hat_pkg::VALUE_BITS'($urandom));
               send_request(hat_pkg::OP_NEXT, $urandom, hat_pkg::VALUE_BITS'($urandom));
            end
            default: begin
               int n;
               n = $urandom_range(1, 30);
               repeat (n) send_request(hat_pkg::OP_INSERT, random_key(), random_amount());
               repeat ($urandom_range(0, n + 3)) send_request(hat_pkg::OP_NEXT, '0, '0);
               if ($urandom_range(0, 3) == 0) send_request(hat_pkg::OP_CLEAR, '0, '0);
            end
         endcase
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests: %0d new, %0d accumulated, %0d rejected as full,",
               requests_sent, board.status_seen[hat_pkg::STATUS_NEW],
               board.status_seen[hat_pkg::STATUS_ACCUM],
               board.status_seen[hat_pkg::STATUS_FULL]);
      $display("%0d clears, %0d entries returned and %0d end-of-list answers.",
               board.status_seen[hat_pkg::STATUS_CLEARED],
               board.status_seen[hat_pkg::STATUS_ENTRY],
               board.status_seen[hat_pkg::STATUS_NONE]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- hash_accumulate_table.f -----
rtl/hat_pkg.sv
rtl/hat_ram.sv
rtl/hash_accumulate_table.sv
verif/tb_hash_accumulate_table.sv
